[design/i2c_master_transaction_sequencer_top_assert.svh]
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_TOP_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_TOP_ASSERT_SVH

// Condition that must hold on every clock edge out of reset
`define I2CS_CHECK(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("i2cs: invariant violated");

// Same-cycle implication
`define I2CS_CHECK_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cs: implication violated");

// Next-cycle implication
`define I2CS_CHECK_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cs: next-cycle implication violated");

`endif

[design/i2cs_pkg.sv]
package i2cs_pkg;

    // Buffer size default and width of the request index field
    localparam int unsigned BUFFER_DEPTH_DEF = 256;
    localparam int unsigned IDX_W            = 8;
    localparam int unsigned IDX_SPAN         = 1 << IDX_W;

    // Request operation codes
    localparam logic [2:0] OP_LOAD  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_XFER  = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_TAKE  = 3'd4;

    // Byte engine action codes
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_START   = 3'd1;
    localparam logic [2:0] ACT_SEND    = 3'd2;
    localparam logic [2:0] ACT_RESTART = 3'd3;
    localparam logic [2:0] ACT_RECV    = 3'd4;
    localparam logic [2:0] ACT_TAKE    = 3'd5;
    localparam logic [2:0] ACT_LAST    = 3'd6;
    localparam logic [2:0] ACT_STOP    = 3'd7;

    // Transaction phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_WADDR  = 5'b00010,
        PH_WDATA  = 5'b00100,
        PH_RSETUP = 5'b01000,
        PH_RDATA  = 5'b10000
    } t_phase;

    // One incoming request
    typedef struct packed {
        logic [2:0]       operation;
        logic [IDX_W-1:0] buffer_index;
        logic [7:0]       byte_value;
        logic [6:0]       target_address;
        logic [7:0]       write_count;
        logic [7:0]       read_count;
        logic             bus_busy;
        logic             nack_received;
        logic [7:0]       received_byte;
    } t_item;

    // Result fields; tx_mem / rd_mem select the registered buffer byte
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic       tx_mem;
        logic       send_nack;
        logic       rd_mem;
        logic       ready_res;
        logic       data_ready;
    } t_res;

    // Buffer write control
    typedef struct packed {
        logic       we;
        logic [7:0] wdata;
    } t_mem_wr;

endpackage

[design/i2cs_buf.sv]
module i2cs_buf #(
    parameter int unsigned BUFFER_DEPTH = i2cs_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  i2cs_pkg::t_mem_wr               i_wr,
    input  logic                            i_rd_en,
    input  logic [$clog2(BUFFER_DEPTH)-1:0] i_addr,
    output logic [7:0]                      o_rdata
);
    import i2cs_pkg::*;

    logic [7:0] r_mem [BUFFER_DEPTH];
    logic [7:0] r_rdata;

    // Single port: a write and a registered read can share one request's address
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_addr] <= i_wr.wdata;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/i2cs_seq.sv]
`include "i2c_master_transaction_sequencer_top_assert.svh"

module i2cs_seq #(
    parameter int unsigned BUFFER_DEPTH = i2cs_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  i2cs_pkg::t_item                 i_item,
    output i2cs_pkg::t_res                  o_res,
    output i2cs_pkg::t_mem_wr               o_mem_wr,
    output logic [$clog2(BUFFER_DEPTH)-1:0] o_mem_addr
);
    import i2cs_pkg::*;

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);

    t_phase     r_phase, n_phase;
    logic [7:0] r_addr_byte, n_addr_byte;
    logic [7:0] r_writes_left, n_writes_left;
    logic [7:0] r_reads_left, n_reads_left;
    logic [7:0] r_buf_pos, n_buf_pos;
    logic       r_read_done, n_read_done;

    t_res       w_res;
    t_mem_wr    w_wr;
    logic       w_use_pos;
    logic [7:0] w_wl;
    logic [7:0] w_rl;
    logic [7:0] w_pos_sel;
    logic       w_wr_phase;
    logic [AW-1:0] w_slot [IDX_SPAN];

    // Index to buffer slot: modulo the depth, worked out per entry
    for (genvar g = 0; g < IDX_SPAN; g++) begin : g_slot
        assign w_slot[g] = AW'(g % BUFFER_DEPTH);
    end

    assign w_wl = r_writes_left - 8'd1;
    assign w_rl = r_reads_left - 8'd1;

    // Next state and result for the request in the input stage
    always_comb begin
        n_phase       = r_phase;
        n_addr_byte   = r_addr_byte;
        n_writes_left = r_writes_left;
        n_reads_left  = r_reads_left;
        n_buf_pos     = r_buf_pos;
        n_read_done   = r_read_done;
        w_res         = '0;
        w_res.action  = ACT_NONE;
        w_wr          = '0;
        w_use_pos     = 1'b0;

        case (i_item.operation)
            OP_LOAD: begin
                w_wr.we    = 1'b1;
                w_wr.wdata = i_item.byte_value;
            end
            OP_START: begin
                if (!i_item.bus_busy && r_phase == PH_IDLE &&
                    (i_item.write_count != 8'd0 || i_item.read_count != 8'd0)) begin
                    n_writes_left = i_item.write_count;
                    n_reads_left  = i_item.read_count;
                    n_addr_byte   = {i_item.target_address, i_item.write_count == 8'd0};
                    n_phase       = (i_item.write_count != 8'd0) ? PH_WADDR : PH_RSETUP;
                    n_buf_pos     = 8'd0;
                    w_res.action  = ACT_START;
                    w_res.tx_byte = {i_item.target_address, i_item.write_count == 8'd0};
                end
            end
            OP_XFER: begin
                case (r_phase)
                    PH_WADDR: begin
                        if (i_item.nack_received) begin
                            n_phase      = PH_IDLE;
                            n_buf_pos    = 8'd0;
                            w_res.action = ACT_STOP;
                        end else begin
                            w_use_pos    = 1'b1;
                            w_res.tx_mem = 1'b1;
                            n_buf_pos    = r_buf_pos + 8'd1;
                            n_phase      = PH_WDATA;
                            w_res.action = ACT_SEND;
                        end
                    end
                    PH_WDATA: begin
                        if (i_item.nack_received) begin
                            n_phase      = PH_IDLE;
                            n_buf_pos    = 8'd0;
                            w_res.action = ACT_STOP;
                        end else begin
                            n_writes_left = w_wl;
                            if (w_wl != 8'd0) begin
                                w_use_pos    = 1'b1;
                                w_res.tx_mem = 1'b1;
                                n_buf_pos    = r_buf_pos + 8'd1;
                                w_res.action = ACT_SEND;
                            end else if (r_reads_left != 8'd0) begin
                                // switch direction with a repeated start
                                w_res.tx_byte = r_addr_byte | 8'h01;
                                n_phase       = PH_RSETUP;
                                n_buf_pos     = 8'd0;
                                w_res.action  = ACT_RESTART;
                            end else begin
                                n_phase      = PH_IDLE;
                                n_buf_pos    = 8'd0;
                                w_res.action = ACT_STOP;
                            end
                        end
                    end
                    PH_RSETUP: begin
                        if (i_item.nack_received) begin
                            n_phase      = PH_IDLE;
                            n_buf_pos    = 8'd0;
                            w_res.action = ACT_STOP;
                        end else begin
                            w_res.send_nack = (r_reads_left == 8'd1);
                            n_phase         = PH_RDATA;
                            w_res.action    = ACT_RECV;
                        end
                    end
                    PH_RDATA: begin
                        // target nack is ignored while receiving
                        n_reads_left = w_rl;
                        w_use_pos    = 1'b1;
                        w_wr.we      = 1'b1;
                        w_wr.wdata   = i_item.received_byte;
                        n_buf_pos    = r_buf_pos + 8'd1;
                        if (w_rl != 8'd0) begin
                            w_res.send_nack = (w_rl == 8'd1);
                            w_res.action    = ACT_TAKE;
                        end else begin
                            n_read_done  = 1'b1;
                            n_phase      = PH_IDLE;
                            n_buf_pos    = 8'd0;
                            w_res.action = ACT_LAST;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_READ: begin
                w_res.rd_mem = 1'b1;
            end
            OP_TAKE: begin
                n_read_done = 1'b0;
            end
            default: begin
            end
        endcase

        w_res.ready_res  = (n_phase == PH_IDLE) && !i_item.bus_busy;
        w_res.data_ready = (i_item.operation == OP_TAKE) ? r_read_done : n_read_done;
    end

    assign w_pos_sel     = w_use_pos ? r_buf_pos : i_item.buffer_index;
    assign o_mem_addr    = w_slot[w_pos_sel];
    assign o_mem_wr.we   = w_wr.we & i_adv;
    assign o_mem_wr.wdata = w_wr.wdata;
    assign o_res         = w_res;

    // Transaction state, committed when the request moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_addr_byte   <= 8'd0;
            r_writes_left <= 8'd0;
            r_reads_left  <= 8'd0;
            r_buf_pos     <= 8'd0;
            r_read_done   <= 1'b0;
        end else if (i_adv) begin
            r_phase       <= n_phase;
            r_addr_byte   <= n_addr_byte;
            r_writes_left <= n_writes_left;
            r_reads_left  <= n_reads_left;
            r_buf_pos     <= n_buf_pos;
            r_read_done   <= n_read_done;
        end
    end

    // Either write phase
    assign w_wr_phase = r_phase inside {PH_WADDR, PH_WDATA};

    `I2CS_CHECK(a_phase_onehot, i_clk, i_rst_n, $onehot(r_phase))
    `I2CS_CHECK_IMP(a_idle_pos_zero, i_clk, i_rst_n, r_phase == PH_IDLE, r_buf_pos == 8'd0)
    `I2CS_CHECK_IMP(a_rdata_left, i_clk, i_rst_n, r_phase == PH_RDATA, r_reads_left != 8'd0)
    `I2CS_CHECK_IMP(a_write_left, i_clk, i_rst_n, w_wr_phase, r_writes_left != 8'd0)

endmodule

[design/i2c_master_transaction_sequencer_top.sv]
// Channel  | Handshake                    | Payload
// request  | i_in_valid / o_in_ready      | i_operation .. i_received_byte
// result   | o_out_valid / i_out_ready    | o_action .. o_data_ready
//
// One request per cycle while results are not stalled; a result is presented
// once its request has passed the input register, then the result register.
// Each request reads the single buffer port and may also write it at the same
// address; the registered read data is muxed onto o_tx_byte / o_read_data.
// Reset clears the phase machine and counts; the buffer is not cleared.
// A stalled result holds the result register and, behind it, the input
// register; requests are taken again as soon as the result is taken.
`include "i2c_master_transaction_sequencer_top_assert.svh"

module i2c_master_transaction_sequencer_top #(
    parameter int unsigned BUFFER_DEPTH = i2cs_pkg::BUFFER_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_operation,
    input  logic [7:0] i_buffer_index,
    input  logic [7:0] i_byte_value,
    input  logic [6:0] i_target_address,
    input  logic [7:0] i_write_count,
    input  logic [7:0] i_read_count,
    input  logic       i_bus_busy,
    input  logic       i_nack_received,
    input  logic [7:0] i_received_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_action,
    output logic [7:0] o_tx_byte,
    output logic       o_send_nack,
    output logic [7:0] o_read_data,
    output logic       o_ready_res,
    output logic       o_data_ready
);
    import i2cs_pkg::*;

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);

    logic          r_in_valid;
    t_item         r_item;
    logic          r_out_valid;
    t_res          r_res;
    logic          w_adv;
    t_res          w_res;
    t_mem_wr       w_mem_wr;
    logic [AW-1:0] w_mem_addr;
    logic [7:0]    w_mem_q;
    logic          w_tx_act;
    logic          w_rx_act;

    // Request moves from input register to result register
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.operation      <= i_operation;
            r_item.buffer_index   <= i_buffer_index;
            r_item.byte_value     <= i_byte_value;
            r_item.target_address <= i_target_address;
            r_item.write_count    <= i_write_count;
            r_item.read_count     <= i_read_count;
            r_item.bus_busy       <= i_bus_busy;
            r_item.nack_received  <= i_nack_received;
            r_item.received_byte  <= i_received_byte;
        end
    end

    i2cs_seq #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_item     (r_item),
        .o_res      (w_res),
        .o_mem_wr   (w_mem_wr),
        .o_mem_addr (w_mem_addr)
    );

    i2cs_buf #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_wr    (w_mem_wr),
        .i_rd_en (w_adv),
        .i_addr  (w_mem_addr),
        .o_rdata (w_mem_q)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_action     = r_res.action;
    assign o_tx_byte    = r_res.tx_mem ? w_mem_q : r_res.tx_byte;
    assign o_send_nack  = r_res.send_nack;
    assign o_read_data  = r_res.rd_mem ? w_mem_q : 8'd0;
    assign o_ready_res  = r_res.ready_res;
    assign o_data_ready = r_res.data_ready;

    // Actions that carry a byte to send, and receive actions
    assign w_tx_act = o_action inside {ACT_START, ACT_SEND, ACT_RESTART};
    assign w_rx_act = o_action inside {ACT_RECV, ACT_TAKE};

    `I2CS_CHECK_NXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_adv, r_in_valid)
    `I2CS_CHECK_IMP(a_tx_zero, i_clk, i_rst_n, o_out_valid && !w_tx_act, o_tx_byte == 8'd0)
    `I2CS_CHECK_IMP(a_nack_recv, i_clk, i_rst_n, o_out_valid && o_send_nack, w_rx_act)

endmodule
